### rtl/sipq_pkg.sv
// Shared types, sizes and codes of the sorted-insert priority queue.
package sipq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;
    localparam int DATA_W      = 32;

    localparam logic       REQ_ENQ   = 1'b0;
    localparam logic       REQ_DEQ   = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic signed [DATA_W-1:0] new_value;
        logic signed [DATA_W-1:0] new_prio;
    } cell_cmd_t;

endpackage

### rtl/sipq_cell.sv
// One storage cell of the sorted chain: holds an entry, shifts right on insert, left on removal.
module sipq_cell
(
    input  logic              clk,
    input  sipq_pkg::cell_cmd_t cmd,
    input  logic              occupied,
    input  logic              left_take,
    input  sipq_pkg::entry_t  left_data,
    input  sipq_pkg::entry_t  right_data,
    output logic              take,
    output sipq_pkg::entry_t  data
);
    import sipq_pkg::*;

    entry_t data_reg;
    entry_t data_next;

    // A cell takes part in an insert when it is free or holds a strictly larger key.
    assign take = !occupied || ($signed(data_reg.prio) > $signed(cmd.new_prio));
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.enq && take)
        begin
            if (left_take)
            begin
                data_next = left_data;
            end
            else
            begin
                data_next.value = cmd.new_value;
                data_next.prio  = cmd.new_prio;
            end
        end
        else if (cmd.deq)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

### rtl/sorted_insert_priority_queue_unit.sv
// Sorted-insert priority queue: a chain of entry cells with an occupancy counter.
//
// Usage:
//   Requests arrive on in_valid / in_stall with req_type, item_value and
//   item_priority. req_type 0 inserts the pair behind every stored entry of
//   smaller or equal priority; req_type 1 removes the head (lowest priority).
//   Each request gives one result on out_valid / out_stall: out_value (head
//   value on a good removal, else 0), status (0 ok, 1 full and insert
//   dropped, 2 removal from empty) and occupancy after the request.
//   The result is registered at the edge that accepts the request. Throughput
//   is one request per cycle while in_stall is low; every cell compares its
//   key with the new one and shifts in the same cycle, so the chain settles
//   in a single step whatever the depth.
//   in_stall rises only while a result is held and out_stall is high; the
//   next request is taken in the same cycle the held result leaves.
//   Reset empties the queue at once (occupancy counter to zero) and clears
//   the output valid flag; cell contents are not cleared.
module sorted_insert_priority_queue_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                req_type,
    input  logic signed [31:0]  item_value,
    input  logic signed [31:0]  item_priority,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  out_value,
    output logic [1:0]          status,
    output logic [4:0]          occupancy
);
    import sipq_pkg::*;

    logic                    accept;
    logic                    full;
    logic                    empty;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    cell_cmd_t               cmd;
    logic [QUEUE_DEPTH-1:0]  occ;
    logic [QUEUE_DEPTH-1:0]  take;
    entry_t                  cell_data [QUEUE_DEPTH];

    logic                    out_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic [1:0]              status_reg;
    logic [OCC_W-1:0]        occupancy_reg;
    logic signed [DATA_W-1:0] out_value_next;
    logic [1:0]              status_next;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    assign cmd.enq       = accept && (req_type == REQ_ENQ) && !full;
    assign cmd.deq       = accept && (req_type == REQ_DEQ) && !empty;
    assign cmd.new_value = item_value;
    assign cmd.new_prio  = item_priority;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_d;
            entry_t right_d;
            logic   left_t;

            assign occ[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_first
                assign left_t = 1'b0;
                assign left_d = '0;
            end
            else
            begin : g_mid
                assign left_t = take[gi-1];
                assign left_d = cell_data[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_inner
                assign right_d = cell_data[gi+1];
            end

            sipq_cell u_cell
            (
                .clk        (clk),
                .cmd        (cmd),
                .occupied   (occ[gi]),
                .left_take  (left_t),
                .left_data  (left_d),
                .right_data (right_d),
                .take       (take[gi]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        out_value_next = '0;
        status_next    = ST_OK;
        if (req_type == REQ_ENQ)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                out_value_next = cell_data[0].value;
                count_next     = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            // Hold the result while stalled, drop it once taken.
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg <= out_value_next;
            status_reg    <= status_next;
            occupancy_reg <= OCC_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy counter beyond queue depth");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_ENQ) && full) |=> (count_reg == $past(count_reg)))
        else $error("dropped insert changed the occupancy");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (out_value == '0))
        else $error("rejected request returned a non-zero value");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        occ[1] |-> ($signed(cell_data[0].prio) <= $signed(cell_data[1].prio)))
        else $error("head entries out of priority order");
`endif

endmodule

### bench/tb_top.sv
// Self-checking bench for the sorted-insert priority queue with a shadow queue and random stalls.
`timescale 1ns / 100ps

class sorted_queue_checker;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } outcome_t;

    logic signed [31:0] shadow_value[sipq_pkg::QUEUE_DEPTH];
    logic signed [31:0] shadow_prio[sipq_pkg::QUEUE_DEPTH];
    int                 shadow_count = 0;
    outcome_t           awaited_outcomes[$];
    int                 mismatches = 0;
    int                 results_seen = 0;

    // Apply one accepted request to the shadow queue and queue what it must return.
    function void note_request(logic kind, logic signed [31:0] value,
                               logic signed [31:0] prio);
        outcome_t o;
        int       pos;
        o.value  = '0;
        o.status = sipq_pkg::ST_OK;
        if (kind == sipq_pkg::REQ_ENQ)
        begin
            if (shadow_count >= sipq_pkg::QUEUE_DEPTH)
                o.status = sipq_pkg::ST_FULL;
            else
            begin
                // Shift every strictly larger key back; equal keys stay ahead.
                pos = shadow_count;
                while (pos > 0 && shadow_prio[pos-1] > prio)
                begin
                    shadow_value[pos] = shadow_value[pos-1];
                    shadow_prio[pos]  = shadow_prio[pos-1];
                    pos--;
                end
                shadow_value[pos] = value;
                shadow_prio[pos]  = prio;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
                o.status = sipq_pkg::ST_EMPTY;
            else
            begin
                o.value = shadow_value[0];
                for (int k = 1; k < shadow_count; k++)
                begin
                    shadow_value[k-1] = shadow_value[k];
                    shadow_prio[k-1]  = shadow_prio[k];
                end
                shadow_count--;
            end
        end
        o.occupancy = 5'(shadow_count);
        awaited_outcomes.push_back(o);
    endfunction

    function int pending();
        return awaited_outcomes.size();
    endfunction

    task report_mismatch(string msg);
        if (mismatches < 100)
            $display("%0t result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task check_result(logic signed [31:0] value, logic [1:0] status, logic [4:0] occupancy);
        outcome_t o;
        results_seen++;
        if (awaited_outcomes.size() == 0)
            report_mismatch("result with no request outstanding");
        else
        begin
            o = awaited_outcomes.pop_front();
            if (value !== o.value)
                report_mismatch($sformatf("out_value %h, want %h", value, o.value));
            if (status !== o.status)
                report_mismatch($sformatf("status %0d, want %0d", status, o.status));
            if (occupancy !== o.occupancy)
                report_mismatch($sformatf("occupancy %0d, want %0d", occupancy, o.occupancy));
        end
    endtask

endclass

module tb_top;

    import sipq_pkg::*;

    localparam int RANDOM_REQUESTS = 1325;
    localparam int IDLE_LIMIT      = 2000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               req_type;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic [4:0]         occupancy;

    sorted_queue_checker sb = new();

    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    sorted_insert_priority_queue_unit i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Send one request, opening a new burst after a random gap when the last one ends.
    task issue(logic kind, logic signed [31:0] value, logic signed [31:0] prio);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid      <= 1'b1;
        req_type      <= kind;
        item_value    <= value;
        item_priority <= prio;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_request(kind, value, prio);
    endtask

    // Hold the sender until every outstanding result has been returned.
    task drain_wait();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Receiver back-pressure: segments of no stall, light, heavy or solid stall.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(1, 12) : $urandom_range(1, 40);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_value, status, occupancy);
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic               kind;
        logic signed [31:0] prio;
        int                 deq_pct;
        int                 phase_left;

        deq_pct    = 50;
        phase_left = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        req_type      <= REQ_ENQ;
        item_value    <= '0;
        item_priority <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty removal, extreme keys, ties, fill to full, overflow, removals.
        issue(REQ_DEQ, 32'sh1234_5678, 32'sh7fff_ffff);
        issue(REQ_ENQ, 32'sh7fff_ffff, 32'sh7fff_ffff);
        issue(REQ_ENQ, 32'sh8000_0000, 32'sh8000_0000);
        issue(REQ_ENQ, 32'sh0000_0000, 32'sh0000_0000);
        issue(REQ_ENQ, 32'shffff_ffff, 32'shffff_ffff);
        issue(REQ_ENQ, 32'sh0000_0001, 32'sh0000_0000);
        issue(REQ_ENQ, 32'sh0000_0002, 32'sh7fff_ffff);
        issue(REQ_ENQ, 32'sh0000_0003, 32'sh8000_0000);
        for (int k = 0; k < 9; k++)
            issue(REQ_ENQ, $urandom, $urandom_range(0, 4) - 2);
        issue(REQ_ENQ, 32'sh5555_5555, 32'sh8000_0000);
        issue(REQ_ENQ, 32'shaaaa_aaaa, 32'sh7fff_ffff);
        for (int k = 0; k < 3; k++)
            issue(REQ_DEQ, $urandom, $urandom);
        issue(REQ_ENQ, $urandom, 32'sh8000_0000);
        issue(REQ_ENQ, $urandom, 32'sh7fff_ffff);
        drain_wait();

        // Random: phases biased to fill, drain or balance so both full and empty recur.
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: deq_pct = 20;
                    1: deq_pct = 80;
                    default: deq_pct = 50;
                endcase
                phase_left = $urandom_range(10, 60);
            end
            phase_left--;
            kind = ($urandom_range(0, 99) < deq_pct) ? REQ_DEQ : REQ_ENQ;
            case ($urandom_range(0, 3))
                0: prio = $urandom_range(0, 6) - 3;
                1:
                begin
                    case ($urandom_range(0, 3))
                        0: prio = 32'sh8000_0000;
                        1: prio = 32'sh7fff_ffff;
                        2: prio = 32'sh0000_0000;
                        default: prio = 32'shffff_ffff;
                    endcase
                end
                default: prio = $urandom;
            endcase
            issue(kind, $urandom, prio);
            if ($urandom_range(0, 149) == 0)
                drain_wait();
        end

        drain_wait();
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/sipq_pkg.sv
rtl/sipq_cell.sv
rtl/sorted_insert_priority_queue_unit.sv
bench/tb_top.sv
